/* sv/sine_cosine_approximator_top_assert.svh */
// assertion macros for the sine/cosine approximator
`ifndef SINE_COSINE_APPROXIMATOR_TOP_ASSERT_SVH
`define SINE_COSINE_APPROXIMATOR_TOP_ASSERT_SVH

// checked only out of reset
`define SCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define SCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/sca_pkg.sv */
// shared constants and helpers for the sine/cosine approximator
package sca_pkg;

  localparam int ANGLE_W               = 32;
  localparam int VALUE_W               = 16;
  localparam int ANGLE_FRAC_BITS_DFLT  = 24;
  localparam int RESULT_FRAC_BITS_DFLT = 14;

  // polynomial datapath: Q.30
  localparam int POLY_FRAC = 30;
  localparam int R30_W     = 32;
  localparam int P_W       = 32;

  localparam int RR_STAGES   = 7;
  localparam int PE_STAGES   = 6;
  localparam int PIPE_STAGES = RR_STAGES + PE_STAGES;

  localparam logic REQ_SINE   = 1'b0;
  localparam logic REQ_COSINE = 1'b1;

  // pi, pi/2 and 2pi with 60 fraction bits
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;

  localparam logic signed [P_W-1:0] COEF1 = 32'sd1073738173;
  localparam logic signed [P_W-1:0] COEF3 = -32'sd178937185;
  localparam logic signed [P_W-1:0] COEF5 = 32'sd8923802;
  localparam logic signed [P_W-1:0] COEF7 = -32'sd197171;

  // round half up from 60 fraction bits down to frac_bits
  function automatic logic [63:0] q60_to_fix(input logic [63:0] c, input int frac_bits);
    q60_to_fix = (c + (64'd1 << (59 - frac_bits))) >> (60 - frac_bits);
  endfunction

endpackage

/* sv/sca_if.sv */
// request and response channels of the sine/cosine approximator
interface sca_req_if import sca_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output req_type, output angle, input ready);
  modport sink (input valid, input req_type, input angle, output ready);
endinterface

interface sca_rsp_if import sca_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

/* sv/sca_range_reduce.sv */
// range reduction pipeline: cosine offset, k = round(x / 2pi), wrap and fold to Q.30
module sca_range_reduce import sca_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DFLT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  sca_req_if.sink                 req_i,
  output logic                    mid_valid_o,
  input  logic                    mid_ready_i,
  output logic signed [R30_W-1:0] mid_r30_o
);

  localparam int XW  = ANGLE_W + 1;
  localparam int NW  = ANGLE_W + 2;
  localparam int RW  = ANGLE_FRAC_BITS + 4;
  localparam int SHL = POLY_FRAC - ANGLE_FRAC_BITS;

  localparam logic [63:0] PI_L    = q60_to_fix(PI_Q60, ANGLE_FRAC_BITS);
  localparam logic [63:0] HALF_L  = q60_to_fix(HALF_PI_Q60, ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_L   = q60_to_fix(TWO_PI_Q60, ANGLE_FRAC_BITS);
  // quotient estimate is at most one below the true value
  localparam logic [63:0] RECIP_L = (64'd1 << NW) / (TWO_L << 1);
  localparam int          QW      = $clog2(RECIP_L + 64'd1);

  localparam logic [QW-1:0]        RECIP_C = RECIP_L[QW-1:0];
  localparam logic [NW-1:0]        TWO_N   = TWO_L[NW-1:0];
  localparam logic [NW-1:0]        DIV_N   = {TWO_L[NW-2:0], 1'b0};
  localparam logic [XW-1:0]        HALF_X  = HALF_L[XW-1:0];
  localparam logic signed [RW-1:0] PI_R    = PI_L[RW-1:0];
  localparam logic signed [RW-1:0] HALF_R  = HALF_L[RW-1:0];
  localparam logic signed [RW-1:0] TWO_R   = TWO_L[RW-1:0];

  logic [RR_STAGES-1:0] vld_q, vld_d;
  logic [RR_STAGES:0]   en;

  always_comb begin
    en[RR_STAGES] = mid_ready_i;
    for (int i = RR_STAGES - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign vld_d       = {vld_q[RR_STAGES-2:0], req_i.valid};
  assign req_i.ready = en[0];
  assign mid_valid_o = vld_q[RR_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < RR_STAGES; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_d[i];
        end
      end
    end
  end

  // stage 0: cosine offset and numerator 2|x| + 2pi
  logic signed [XW-1:0] x_d, x0_q;
  logic [ANGLE_W-1:0]   mag_d;
  logic [NW-1:0]        n_d, n0_q;

  always_comb begin
    x_d   = {req_i.angle[ANGLE_W-1], req_i.angle}
          + ((req_i.req_type == REQ_COSINE) ? HALF_X : '0);
    mag_d = x_d[XW-1] ? ANGLE_W'(-x_d) : x_d[ANGLE_W-1:0];
    n_d   = {1'b0, mag_d, 1'b0} + TWO_N;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q <= x_d;
      n0_q <= n_d;
    end
  end

  // stage 1: quotient estimate by reciprocal
  logic [NW+QW-1:0]     qprod;
  logic [QW-1:0]        q1_q;
  logic signed [XW-1:0] x1_q;
  logic [NW-1:0]        n1_q;

  assign qprod = n0_q * RECIP_C;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      q1_q <= qprod[NW+QW-1:NW];
      x1_q <= x0_q;
      n1_q <= n0_q;
    end
  end

  // stage 2: back-multiply by 4pi
  logic [NW+QW-1:0]     dprod;
  logic [NW-1:0]        p2_q, n2_q;
  logic signed [XW-1:0] x2_q;

  assign dprod = q1_q * DIV_N;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p2_q <= dprod[NW-1:0];
      n2_q <= n1_q;
      x2_q <= x1_q;
    end
  end

  // stage 3: one correction step, |k| * 2pi
  logic [NW-1:0]        rem, kt_d, kt3_q;
  logic                 corr;
  logic signed [XW-1:0] x3_q;

  always_comb begin
    rem  = n2_q - p2_q;
    corr = (rem >= DIV_N);
    kt_d = {1'b0, p2_q[NW-1:1]} + (corr ? TWO_N : '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      kt3_q <= kt_d;
      x3_q  <= x2_q;
    end
  end

  // stage 4: remainder
  logic signed [NW:0]   xe, ke, rs;
  logic signed [RW-1:0] r4_q;

  always_comb begin
    xe = {{2{x3_q[XW-1]}}, x3_q};
    ke = {1'b0, kt3_q};
    rs = x3_q[XW-1] ? (xe + ke) : (xe - ke);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      r4_q <= rs[RW-1:0];
    end
  end

  // stage 5: wrap into [-pi, pi]
  logic signed [RW-1:0] r5_d, r5_q;

  always_comb begin
    if (r4_q > PI_R) begin
      r5_d = r4_q - TWO_R;
    end else if (r4_q < -PI_R) begin
      r5_d = r4_q + TWO_R;
    end else begin
      r5_d = r4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      r5_q <= r5_d;
    end
  end

  // stage 6: reflect into [-pi/2, pi/2], then scale to Q.30
  logic signed [RW-1:0]    r6_d;
  logic signed [R30_W-1:0] r30_d, r30_q;

  always_comb begin
    if (r5_q > HALF_R) begin
      r6_d = PI_R - r5_q;
    end else if (r5_q < -HALF_R) begin
      r6_d = -PI_R - r5_q;
    end else begin
      r6_d = r5_q;
    end
    r30_d = {r6_d[ANGLE_FRAC_BITS+1:0], {SHL{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      r30_q <= r30_d;
    end
  end

  assign mid_r30_o = r30_q;

endmodule

/* sv/sca_poly_eval.sv */
// odd degree-7 polynomial by Horner in r squared, output rounding and saturation
module sca_poly_eval import sca_pkg::*; #(
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DFLT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    mid_valid_i,
  output logic                    mid_ready_o,
  input  logic signed [R30_W-1:0] mid_r30_i,
  sca_rsp_if.source               rsp_o
);

  localparam int R2_W  = R30_W + 1;
  localparam int SQ_W  = 2 * R30_W;
  localparam int PM_W  = R2_W + P_W;
  localparam int TW    = PM_W - POLY_FRAC;
  localparam int RES_W = SQ_W - POLY_FRAC;
  localparam int FW    = RES_W + 1;
  localparam int SH    = POLY_FRAC - RESULT_FRAC_BITS;

  localparam logic signed [SQ_W-1:0] RND_SQ = SQ_W'(64'd1 << (POLY_FRAC - 1));
  localparam logic signed [PM_W-1:0] RND_PM = PM_W'(64'd1 << (POLY_FRAC - 1));
  localparam logic signed [FW-1:0]   RND_F  =
    (SH == 0) ? '0 : FW'(64'd1 << ((SH == 0) ? 0 : SH - 1));
  localparam logic signed [FW-1:0]   LIM_F  = FW'(64'd1 << RESULT_FRAC_BITS);

  // c + round(r2 * p / 2^30)
  function automatic logic signed [P_W-1:0] horner_step(
    input logic signed [R2_W-1:0] r2,
    input logic signed [P_W-1:0]  p,
    input logic signed [P_W-1:0]  c
  );
    logic signed [PM_W-1:0] pm;
    logic signed [PM_W-1:0] pr;
    logic signed [TW-1:0]   t;
    logic signed [TW-1:0]   s;
    pm = r2 * p;
    pr = pm + RND_PM;
    t  = pr[PM_W-1:POLY_FRAC];
    s  = t + c;
    horner_step = s[P_W-1:0];
  endfunction

  logic [PE_STAGES-1:0] vld_q, vld_d;
  logic [PE_STAGES:0]   en;

  always_comb begin
    en[PE_STAGES] = rsp_o.ready;
    for (int i = PE_STAGES - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign vld_d       = {vld_q[PE_STAGES-2:0], mid_valid_i};
  assign mid_ready_o = en[0];
  assign rsp_o.valid = vld_q[PE_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < PE_STAGES; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_d[i];
        end
      end
    end
  end

  // stage 0: r squared
  logic signed [SQ_W-1:0]  sq, sqr;
  logic signed [R2_W-1:0]  r2_0_q;
  logic signed [R30_W-1:0] r30_0_q;

  always_comb begin
    sq  = mid_r30_i * mid_r30_i;
    sqr = sq + RND_SQ;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r2_0_q  <= sqr[POLY_FRAC+R2_W-1:POLY_FRAC];
      r30_0_q <= mid_r30_i;
    end
  end

  // stages 1 to 3: Horner steps
  logic signed [P_W-1:0]   p1_q, p2_q, p3_q;
  logic signed [R2_W-1:0]  r2_1_q, r2_2_q;
  logic signed [R30_W-1:0] r30_1_q, r30_2_q, r30_3_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p1_q    <= horner_step(r2_0_q, COEF7, COEF5);
      r2_1_q  <= r2_0_q;
      r30_1_q <= r30_0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p2_q    <= horner_step(r2_1_q, p1_q, COEF3);
      r2_2_q  <= r2_1_q;
      r30_2_q <= r30_1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      p3_q    <= horner_step(r2_2_q, p2_q, COEF1);
      r30_3_q <= r30_2_q;
    end
  end

  // stage 4: times r
  logic signed [SQ_W-1:0]  fm, fr;
  logic signed [RES_W-1:0] res_q;

  always_comb begin
    fm = r30_3_q * p3_q;
    fr = fm + RND_SQ;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      res_q <= fr[SQ_W-1:POLY_FRAC];
    end
  end

  // stage 5: round to the output format and clamp to +/-1.0
  logic signed [FW-1:0]      fe, fa, fs, fsat;
  logic signed [VALUE_W-1:0] val_q;

  always_comb begin
    fe = {res_q[RES_W-1], res_q};
    fa = fe + RND_F;
    fs = fa >>> SH;
    if (fs > LIM_F) begin
      fsat = LIM_F;
    end else if (fs < -LIM_F) begin
      fsat = -LIM_F;
    end else begin
      fsat = fs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      val_q <= fsat[VALUE_W-1:0];
    end
  end

  assign rsp_o.value = val_q;

endmodule

/* sv/sine_cosine_approximator_top.sv */
// Sine/cosine approximator. Each request transfer carries an angle in radians
// (signed, ANGLE_FRAC_BITS fraction bits) and a sine/cosine select; each
// response transfer returns the value as signed RESULT_FRAC_BITS fraction bits,
// clamped to +/-1.0, in request order. The datapath is a 13-stage pipeline:
// seven stages of range reduction (cosine offset, reciprocal quotient estimate,
// back-multiply, correction, remainder, wrap, fold) and six of polynomial
// evaluation (r squared, three Horner steps, the final multiply by r, and
// rounding into the output register). One item is accepted every cycle until
// output back-pressure has filled all stages; each multiplier has a stage of
// its own, which sets the clock. Every stage holds its item until the next
// stage frees up, so output back-pressure first squeezes out empty stages and
// request ready falls only once all 13 stages hold an item.
`include "sine_cosine_approximator_top_assert.svh"

module sine_cosine_approximator_top import sca_pkg::*; #(
  parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_BITS_DFLT,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DFLT
) (
  input logic       clk_i,
  input logic       rst_ni,
  sca_req_if.sink   req_i,
  sca_rsp_if.source rsp_o
);

  logic                    mid_valid;
  logic                    mid_ready;
  logic signed [R30_W-1:0] mid_r30;

  sca_range_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .mid_valid_o(mid_valid),
    .mid_ready_i(mid_ready),
    .mid_r30_o  (mid_r30)
  );

  sca_poly_eval #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_poly (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_valid_i(mid_valid),
    .mid_ready_o(mid_ready),
    .mid_r30_i  (mid_r30),
    .rsp_o      (rsp_o)
  );

  // items between request and response transfer
  localparam int CW = $clog2(PIPE_STAGES + 1);

  logic          in_xfer, out_xfer;
  logic [CW-1:0] inflight_q, inflight_d;

  assign in_xfer    = req_i.valid && req_i.ready;
  assign out_xfer   = rsp_o.valid && rsp_o.ready;
  assign inflight_d = inflight_q + CW'(in_xfer) - CW'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `SCA_ASSERT(a_ready_when_drained, (!rsp_o.valid || rsp_o.ready) |-> req_i.ready, "request stalled with response side free")
  `SCA_ASSERT(a_result_has_source, rsp_o.valid |-> (inflight_q != '0), "response with no item in flight")
  `SCA_ASSERT(a_depth_bound, inflight_q <= CW'(PIPE_STAGES), "more items in flight than stages")
  `SCA_ASSERT(a_full_stalls, ((inflight_q == CW'(PIPE_STAGES)) && !rsp_o.ready) |-> !req_i.ready, "request taken into a full pipeline")
  `SCA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !rsp_o.valid, "response valid during reset")

endmodule
